// ===== sv/fpsa_pkg.sv =====
package fpsa_pkg;

    localparam int MAX_SEGMENTS_DEF = 32;
    localparam int SIZE_W = 24;
    localparam int REQ_W = 16;
    localparam int WORD_W = SIZE_W + 1;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_FIRST = 3'd1;
    localparam logic [2:0] OP_BEST = 3'd2;
    localparam logic [2:0] OP_WORST = 3'd3;
    localparam logic [2:0] OP_MERGE = 3'd4;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NO_FIT = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

endpackage

// ===== sv/fpsa_ram.sv =====
module fpsa_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/fit_policy_segment_allocator_unit.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  operation, request_size
// out      output     out_valid / out_stall status, segment_index, merged_free, segment_count
//
// One request at a time; in_stall is high from acceptance until its result is taken.
// Fit and merge scan the table one segment at a time through the RAM's single read port.
// An insert shifts the entries above the slot up by one, one entry at a time.
// rst_n clears the count and the sequencer; table contents stay undefined until written.
// A stalled result holds in the output registers.
module fit_policy_segment_allocator_unit #(
    parameter int MAX_SEGMENTS = fpsa_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  operation,
    input  logic [fpsa_pkg::REQ_W-1:0]  request_size,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [4:0]                  segment_index,
    output logic [fpsa_pkg::SIZE_W-1:0] merged_free,
    output logic [5:0]                  segment_count
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int SW = fpsa_pkg::SIZE_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_SEGMENTS);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_EV, S_END, S_SHIFT_RD, S_SHIFT_WR, S_INS, S_FIX, S_OUT
    } state_t;

    state_t state_reg;
    logic [2:0] op_reg;
    logic [SW-1:0] req_reg;
    logic [CW-1:0] count_reg, k_reg, w_reg, ptr_reg, lo_reg, pick_reg;
    logic [SW-1:0] pick_size_reg, sum_reg;
    logic found_reg;
    logic [fpsa_pkg::WORD_W-1:0] ins_reg;
    logic [1:0] status_reg;
    logic [CW-1:0] idx_reg;
    logic [SW-1:0] merged_reg;

    logic we;
    logic [IW-1:0] waddr, raddr;
    logic [fpsa_pkg::WORD_W-1:0] wdata, rdata;
    logic r_used, fits;
    logic [SW-1:0] r_size;
    logic [SW:0] sum_add;

    fpsa_ram #(.WIDTH(fpsa_pkg::WORD_W), .DEPTH(MAX_SEGMENTS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign r_used = rdata[SW];
    assign r_size = rdata[SW-1:0];
    assign fits = !r_used && (r_size >= req_reg);
    assign sum_add = {1'b0, sum_reg} + {1'b0, r_size};

    always_comb
    begin
        we = 1'b0;
        waddr = w_reg[IW-1:0];
        wdata = {1'b1, r_size};
        raddr = k_reg[IW-1:0];
        case (state_reg)
            S_SCAN_EV:
            begin
                we = (op_reg == fpsa_pkg::OP_MERGE) && r_used;
            end
            S_SHIFT_RD:
            begin
                raddr = IW'(ptr_reg - CW'(1));
            end
            S_SHIFT_WR:
            begin
                we = 1'b1;
                waddr = ptr_reg[IW-1:0];
                wdata = rdata;
            end
            S_INS:
            begin
                we = 1'b1;
                waddr = lo_reg[IW-1:0];
                wdata = ins_reg;
            end
            S_FIX:
            begin
                we = 1'b1;
                waddr = pick_reg[IW-1:0];
                wdata = {1'b1, req_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg <= operation;
                        req_reg <= SW'(request_size);
                        k_reg <= '0;
                        w_reg <= '0;
                        sum_reg <= '0;
                        found_reg <= 1'b0;
                        status_reg <= fpsa_pkg::ST_DONE;
                        idx_reg <= '0;
                        merged_reg <= '0;
                        if (operation == fpsa_pkg::OP_ADD)
                        begin
                            if (count_reg >= MAX_C)
                            begin
                                status_reg <= fpsa_pkg::ST_FULL;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                lo_reg <= '0;
                                ptr_reg <= count_reg;
                                ins_reg <= {1'b0, SW'(request_size)};
                                state_reg <= S_SHIFT_RD;
                            end
                        end
                        else if (operation inside {[fpsa_pkg::OP_FIRST : fpsa_pkg::OP_MERGE]})
                        begin
                            state_reg <= S_SCAN_RD;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= (k_reg == count_reg) ? S_END : S_SCAN_EV;
                end
                S_SCAN_EV:
                begin
                    k_reg <= k_reg + CW'(1);
                    state_reg <= S_SCAN_RD;
                    if (op_reg == fpsa_pkg::OP_MERGE)
                    begin
                        if (r_used)
                        begin
                            w_reg <= w_reg + CW'(1);
                        end
                        else
                        begin
                            sum_reg <= sum_add[SW] ? fpsa_pkg::SIZE_SAT : sum_add[SW-1:0];
                        end
                    end
                    else if (fits)
                    begin
                        if (!found_reg)
                        begin
                            found_reg <= 1'b1;
                            pick_reg <= k_reg;
                            pick_size_reg <= r_size;
                            if (op_reg == fpsa_pkg::OP_FIRST)
                            begin
                                state_reg <= S_END;
                            end
                        end
                        else if ((op_reg == fpsa_pkg::OP_BEST && r_size < pick_size_reg) ||
                                 (op_reg == fpsa_pkg::OP_WORST && r_size > pick_size_reg))
                        begin
                            pick_reg <= k_reg;
                            pick_size_reg <= r_size;
                        end
                    end
                end
                S_END:
                begin
                    if (op_reg == fpsa_pkg::OP_MERGE)
                    begin
                        count_reg <= w_reg;
                        merged_reg <= sum_reg;
                        if (sum_reg != '0 && w_reg < MAX_C)
                        begin
                            lo_reg <= '0;
                            ptr_reg <= w_reg;
                            ins_reg <= {1'b0, sum_reg};
                            state_reg <= S_SHIFT_RD;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                    else if (!found_reg)
                    begin
                        status_reg <= fpsa_pkg::ST_NO_FIT;
                        state_reg <= S_OUT;
                    end
                    else if (pick_size_reg > req_reg)
                    begin
                        if (count_reg >= MAX_C)
                        begin
                            status_reg <= fpsa_pkg::ST_FULL;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            lo_reg <= pick_reg + CW'(1);
                            ptr_reg <= count_reg;
                            ins_reg <= {1'b0, pick_size_reg - req_reg};
                            idx_reg <= pick_reg;
                            state_reg <= S_SHIFT_RD;
                        end
                    end
                    else
                    begin
                        idx_reg <= pick_reg;
                        state_reg <= S_FIX;
                    end
                end
                S_SHIFT_RD:
                begin
                    state_reg <= (ptr_reg == lo_reg) ? S_INS : S_SHIFT_WR;
                end
                S_SHIFT_WR:
                begin
                    ptr_reg <= ptr_reg - CW'(1);
                    state_reg <= S_SHIFT_RD;
                end
                S_INS:
                begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= (op_reg == fpsa_pkg::OP_ADD || op_reg == fpsa_pkg::OP_MERGE)
                                 ? S_OUT : S_FIX;
                end
                S_FIX:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status = status_reg;
    assign segment_index = 5'(idx_reg);
    assign merged_free = merged_reg;
    assign segment_count = 6'(count_reg);

endmodule
